// ----- rtl/core/mcdv_pkg.sv -----
// ----------------------------------------------------------------------------
// MRZ check digit validator package
// Shared types, format codes and field position tables for the validator.
// ----------------------------------------------------------------------------
package mcdv_pkg;

  localparam int NumFields = 5;

  // Document format codes. The unused code 3 is handled as a passport line.
  localparam logic [1:0] FMT_PASSPORT = 2'd0;
  localparam logic [1:0] FMT_PERMIT1  = 2'd1;
  localparam logic [1:0] FMT_PERMIT2  = 2'd2;

  // ASCII codes of interest.
  localparam logic [7:0] CH_DIGIT_0 = 8'd48;
  localparam logic [7:0] CH_DIGIT_9 = 8'd57;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_FILLER  = 8'd60;
  localparam logic [7:0] CH_A_BIAS  = 8'd55;

  typedef logic [6:0] pos_t;

  // Result of one complete code; all_valid sits in the lowest bit.
  typedef struct packed {
    logic       too_short;
    logic [4:0] field_ok;
    logic       all_valid;
  } mcdv_result_t;

  function automatic logic [1:0] fmt_norm(input logic [1:0] fmt);
    return (fmt == 2'd3) ? FMT_PASSPORT : fmt;
  endfunction

  function automatic pos_t fmt_len(input logic [1:0] fmt);
    pos_t len;
    unique case (fmt_norm(fmt))
      FMT_PERMIT1: len = 7'd30;
      FMT_PERMIT2: len = 7'd60;
      default:     len = 7'd44;
    endcase
    return len;
  endfunction

  function automatic logic [4:0] fmt_mask(input logic [1:0] fmt);
    return (fmt_norm(fmt) == FMT_PERMIT1) ? 5'b01111 : 5'b11111;
  endfunction

  function automatic logic in_rng(input pos_t pos, input pos_t lo, input pos_t hi);
    return (pos >= lo) && (pos <= hi);
  endfunction

  // True when position pos is summed into field f.
  function automatic logic in_field(input logic [1:0] fmt, input logic [2:0] f,
                                    input pos_t pos);
    logic hit;
    hit = 1'b0;
    unique case (fmt_norm(fmt))
      FMT_PERMIT1: begin
        unique case (f)
          3'd0:    hit = in_rng(pos, 7'd2, 7'd10);
          3'd1:    hit = in_rng(pos, 7'd13, 7'd18);
          3'd2:    hit = in_rng(pos, 7'd21, 7'd26);
          3'd3:    hit = in_rng(pos, 7'd2, 7'd11) || in_rng(pos, 7'd13, 7'd19) ||
                         in_rng(pos, 7'd21, 7'd27);
          default: hit = 1'b0;
        endcase
      end
      FMT_PERMIT2: begin
        unique case (f)
          3'd0:    hit = in_rng(pos, 7'd2, 7'd10);
          3'd1:    hit = in_rng(pos, 7'd12, 7'd13);
          3'd2:    hit = in_rng(pos, 7'd15, 7'd20);
          3'd3:    hit = in_rng(pos, 7'd23, 7'd28);
          3'd4:    hit = in_rng(pos, 7'd2, 7'd21) || in_rng(pos, 7'd23, 7'd29) ||
                         in_rng(pos, 7'd49, 7'd58);
          default: hit = 1'b0;
        endcase
      end
      default: begin
        unique case (f)
          3'd0:    hit = in_rng(pos, 7'd0, 7'd8);
          3'd1:    hit = in_rng(pos, 7'd13, 7'd18);
          3'd2:    hit = in_rng(pos, 7'd21, 7'd26);
          3'd3:    hit = in_rng(pos, 7'd28, 7'd41);
          3'd4:    hit = in_rng(pos, 7'd0, 7'd9) || in_rng(pos, 7'd13, 7'd19) ||
                         in_rng(pos, 7'd21, 7'd42);
          default: hit = 1'b0;
        endcase
      end
    endcase
    return hit;
  endfunction

  // True when position pos holds the check character of field f.
  function automatic logic is_chk(input logic [1:0] fmt, input logic [2:0] f,
                                  input pos_t pos);
    logic hit;
    hit = 1'b0;
    unique case (fmt_norm(fmt))
      FMT_PERMIT1: begin
        unique case (f)
          3'd0:    hit = (pos == 7'd11);
          3'd1:    hit = (pos == 7'd19);
          3'd2:    hit = (pos == 7'd27);
          3'd3:    hit = (pos == 7'd29);
          default: hit = 1'b0;
        endcase
      end
      FMT_PERMIT2: begin
        unique case (f)
          3'd0:    hit = (pos == 7'd11);
          3'd1:    hit = (pos == 7'd14);
          3'd2:    hit = (pos == 7'd21);
          3'd3:    hit = (pos == 7'd29);
          3'd4:    hit = (pos == 7'd59);
          default: hit = 1'b0;
        endcase
      end
      default: begin
        unique case (f)
          3'd0:    hit = (pos == 7'd9);
          3'd1:    hit = (pos == 7'd19);
          3'd2:    hit = (pos == 7'd27);
          3'd3:    hit = (pos == 7'd42);
          3'd4:    hit = (pos == 7'd43);
          default: hit = 1'b0;
        endcase
      end
    endcase
    return hit;
  endfunction

  // Remainder by ten through a reciprocal multiply, exact for every 7-bit input.
  function automatic logic [3:0] mod10(input logic [6:0] x);
    logic [14:0] prod;
    logic [3:0]  quo;
    prod = 15'(x) * 15'd205;
    quo  = prod[14:11];
    return 4'(x - 7'(quo) * 7'd10);
  endfunction

endpackage

// ----- rtl/core/mrz_check_digit_validator.sv -----
// ----------------------------------------------------------------------------
// MRZ check digit validator
// Checks the 7-3-1 modulo-10 check digits of a machine readable zone.
// ----------------------------------------------------------------------------
// The accepted request carrying the last character is held in the input
// register, then its verdict goes to the result register that drives tvalid.
// Throughput: one character per cycle, set by the accumulator update; the
// input stalls only while a last character waits behind an untaken result.
// Reset: asynchronous, active low; clears the format (passport line two), the
// position counter, all sums, phases, flags, valids.
module mrz_check_digit_validator import mcdv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write channel: doc_format.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  // Character stream.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  input  logic       s_axis_tlast,   // last character of the code
  // Result stream.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] all_valid, [5:1] field_ok,
                                     // [6] too_short, [7] zero
);

  logic         s1_valid;
  logic [7:0]   s1_ch;
  logic         s1_last;
  logic         s1_advance;
  logic         can_load;
  logic         res_load;
  mcdv_result_t res_d;
  mcdv_result_t res_q;

  // Format register always writable; user writes only while idle, unenforced.
  assign cfg_ready_o = 1'b1;

  // A registered character moves on unless it ends a code and the result
  // register still holds an untaken result.
  assign s1_advance = s1_valid && (!s1_last || can_load);
  assign res_load   = s1_advance && s1_last;

  mcdv_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_ch_i    (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .advance_i  (s1_advance),
    .valid_o    (s1_valid),
    .ch_o       (s1_ch),
    .last_o     (s1_last)
  );

  mcdv_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .step_i     (s1_advance),
    .ch_i       (s1_ch),
    .last_i     (s1_last),
    .result_o   (res_d)
  );

  mcdv_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .result_i    (res_d),
    .can_load_o  (can_load),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (res_q)
  );

  assign m_axis_tdata = {1'b0, res_q};

  // A short code can never pass.
  a_short_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.too_short |-> !res_q.all_valid)
    else $error("short code reported as valid");

  // A passing code has at least the four fields common to every format.
  a_pass_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.all_valid |-> res_q.field_ok[3:0] == 4'hF)
    else $error("pass reported with a failing field");

endmodule

// ----- rtl/core/mcdv_in_stage.sv -----
// ----------------------------------------------------------------------------
// MRZ validator input stage
// Registers one incoming character and its end marker.
// ----------------------------------------------------------------------------
module mcdv_in_stage import mcdv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_ch_i,
  input  logic       in_last_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] ch_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  logic [7:0] ch_q;
  logic       last_q;
  logic       load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ch_q   <= in_ch_i;
      last_q <= in_last_i;
    end
  end

  assign valid_o = valid_q;
  assign ch_o    = ch_q;
  assign last_o  = last_q;

  // A held character that is not consumed stays unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !advance_i |=> valid_q && $stable(ch_q) && $stable(last_q))
    else $error("input stage lost a held character");

endmodule

// ----- rtl/core/mcdv_accum.sv -----
// ----------------------------------------------------------------------------
// MRZ validator accumulator
// Weighted modulo-10 field sums, check comparisons and the end-of-code result.
// ----------------------------------------------------------------------------
module mcdv_accum import mcdv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_data_i,
  input  logic         step_i,
  input  logic [7:0]   ch_i,
  input  logic         last_i,
  output mcdv_result_t result_o
);

  logic [1:0] fmt_q;
  pos_t       char_pos_q, char_pos_d;
  logic [3:0] sum_q   [NumFields];
  logic [3:0] sum_d   [NumFields];
  logic [1:0] phase_q [NumFields];
  logic [1:0] phase_d [NumFields];
  logic [4:0] bad_q, bad_d;
  logic [4:0] match_q, match_d;

  logic [5:0] val;
  logic       bad;
  logic [3:0] val10;
  logic       pos_ok;
  logic [4:0] mask;
  logic       tshort;
  logic [4:0] fok;

  always_comb begin
    val = '0;
    bad = 1'b0;
    if (ch_i >= CH_DIGIT_0 && ch_i <= CH_DIGIT_9) begin
      val = 6'(ch_i - CH_DIGIT_0);
    end else if (ch_i >= CH_UPPER_A && ch_i <= CH_UPPER_Z) begin
      val = 6'(ch_i - CH_A_BIAS);
    end else if (ch_i != CH_FILLER) begin
      bad = 1'b1;
    end
  end

  assign val10  = mod10(7'(val));
  assign pos_ok = char_pos_q < fmt_len(fmt_q);

  always_comb begin
    logic [6:0] wgt;
    logic [6:0] acc;
    logic [3:0] s;
    bad_d   = bad_q;
    match_d = match_q;
    for (int i = 0; i < NumFields; i++) begin
      sum_d[i]   = sum_q[i];
      phase_d[i] = phase_q[i];
      unique case (phase_q[i])
        2'd0:    wgt = 7'd7;
        2'd1:    wgt = 7'd3;
        default: wgt = 7'd1;
      endcase
      acc = 7'(sum_q[i]) + 7'(val10) * wgt;
      if (pos_ok && in_field(fmt_q, 3'(i), char_pos_q)) begin
        if (bad) begin
          bad_d[i] = 1'b1;
        end else begin
          sum_d[i] = mod10(acc);
        end
        phase_d[i] = (phase_q[i] >= 2'd2) ? 2'd0 : 2'(phase_q[i] + 2'd1);
      end
      s = bad_d[i] ? 4'd0 : sum_d[i];
      if (pos_ok && is_chk(fmt_q, 3'(i), char_pos_q)) begin
        match_d[i] = (s == ch_i[3:0]);
      end
    end
  end

  assign char_pos_d = (char_pos_q == '1) ? char_pos_q : 7'(char_pos_q + 7'd1);

  assign mask   = fmt_mask(fmt_q);
  assign tshort = char_pos_d < fmt_len(fmt_q);
  assign fok    = match_d & mask;

  always_comb begin
    result_o.all_valid = !tshort && (fok == mask);
    result_o.field_ok  = fok;
    result_o.too_short = tshort;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q      <= FMT_PASSPORT;
      char_pos_q <= '0;
      bad_q      <= '0;
      match_q    <= '0;
      for (int i = 0; i < NumFields; i++) begin
        sum_q[i]   <= '0;
        phase_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_data_i;
      end
      if (step_i) begin
        if (last_i) begin
          char_pos_q <= '0;
          bad_q      <= '0;
          match_q    <= '0;
          for (int i = 0; i < NumFields; i++) begin
            sum_q[i]   <= '0;
            phase_q[i] <= '0;
          end
        end else begin
          char_pos_q <= char_pos_d;
          bad_q      <= bad_d;
          match_q    <= match_d;
          for (int i = 0; i < NumFields; i++) begin
            sum_q[i]   <= sum_d[i];
            phase_q[i] <= phase_d[i];
          end
        end
      end
    end
  end

  // The end of a code leaves the accumulator clear for the next one.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> char_pos_q == '0 && match_q == '0 && bad_q == '0)
    else $error("accumulator not cleared after end of code");

  // The position counter only moves on a consumed character.
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(char_pos_q))
    else $error("position counter moved without a character");

endmodule

// ----- rtl/core/mcdv_out_stage.sv -----
// ----------------------------------------------------------------------------
// MRZ validator output stage
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
module mcdv_out_stage import mcdv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  mcdv_result_t result_i,
  output logic         can_load_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output mcdv_result_t result_o
);

  logic         valid_q, valid_d;
  mcdv_result_t result_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("output result overwritten");

endmodule

// ----- sim/mrz_check_digit_validator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MRZ check digit validator testbench
// Streams MRZ codes into the validator and checks every verdict against a
// cycle-free model of the 7-3-1 check digit rules in all document formats.
// ----------------------------------------------------------------------------
module mrz_check_digit_validator_test;
  import mcdv_pkg::*;

  // Run control.
  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 8;
  localparam int CycleLimit   = 500000;
  localparam int RandomChars  = 400;
  localparam int MinRandCodes = 8;
  localparam int HoldCycles   = 300;
  localparam int PipeSettle   = 4;
  localparam int FinalSettle  = 12;
  localparam int MaxReported  = 10;

  // A field whose check never fires carries this check position.
  localparam logic [6:0] NoCheck = 7'd127;
  localparam logic [6:0] PosSaturate = 7'd127;

  // Character positions of one checked field: up to three summed ranges and
  // the position of its check character. An unused range is written as 1..0.
  typedef struct packed {
    logic [6:0] chk;
    logic [6:0] lo0;
    logic [6:0] hi0;
    logic [6:0] lo1;
    logic [6:0] hi1;
    logic [6:0] lo2;
    logic [6:0] hi2;
  } span_t;

  // How a generated code is damaged before it is sent.
  typedef enum int {
    CODE_CLEAN,
    CODE_BAD_DIGIT,
    CODE_BAD_CHAR,
    CODE_SHORT,
    CODE_LONG,
    CODE_NOISE
  } code_kind_e;

  // Ready patterns of the result side.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_BURSTY
  } rx_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i = 2'd0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;   // [7:0] ch
  logic       s_axis_tlast = 1'b0;   // last character of the code
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [0] all_valid, [5:1] field_ok,
                                     // [6] too_short, [7] zero

  mrz_check_digit_validator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever begin
      #(ClkPeriod / 2) clk_i = ~clk_i;
    end
  end

  // --------------------------------------------------------------------------
  // Check digit model. It mirrors the block's state: the format register,
  // the position counter and, per field, a mod-10 sum, a weight phase, a
  // bad-character flag and a match flag.
  // --------------------------------------------------------------------------
  logic [1:0] fmt_reg = FMT_PASSPORT;
  logic [6:0] pos_cnt = 7'd0;
  logic [3:0] sum_acc   [NumFields] = '{default: 4'd0};
  logic [1:0] phase_acc [NumFields] = '{default: 2'd0};
  logic [4:0] bad_flags = 5'd0;
  logic [4:0] match_flags = 5'd0;

  // Verdicts predicted for codes whose last character has been accepted.
  mcdv_result_t expected_verdicts [$];

  int mismatches = 0;
  int chars_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;

  // The unused format code behaves as the passport line.
  function automatic logic [1:0] eff_fmt(input logic [1:0] raw);
    return (raw == FMT_PERMIT1 || raw == FMT_PERMIT2) ? raw : FMT_PASSPORT;
  endfunction

  function automatic int code_len(input logic [1:0] f);
    case (f)
      FMT_PERMIT1: return 30;
      FMT_PERMIT2: return 60;
      default:     return 44;
    endcase
  endfunction

  // The single permit line has only four checks, composite in bit 3.
  function automatic logic [4:0] field_mask(input logic [1:0] f);
    return (f == FMT_PERMIT1) ? 5'b01111 : 5'b11111;
  endfunction

  function automatic span_t mk_span(input int chk, input int lo0, input int hi0,
                                    input int lo1, input int hi1,
                                    input int lo2, input int hi2);
    span_t s;
    s.chk = 7'(chk);
    s.lo0 = 7'(lo0);
    s.hi0 = 7'(hi0);
    s.lo1 = 7'(lo1);
    s.hi1 = 7'(hi1);
    s.lo2 = 7'(lo2);
    s.hi2 = 7'(hi2);
    return s;
  endfunction

  // Field layout of each format; the composite is always the last field.
  function automatic span_t span_of(input logic [1:0] f, input int idx);
    span_t s;
    s = mk_span(NoCheck, 1, 0, 1, 0, 1, 0);
    case (f)
      FMT_PERMIT1: begin
        case (idx)
          0: s = mk_span(11, 2, 10, 1, 0, 1, 0);
          1: s = mk_span(19, 13, 18, 1, 0, 1, 0);
          2: s = mk_span(27, 21, 26, 1, 0, 1, 0);
          3: s = mk_span(29, 2, 11, 13, 19, 21, 27);
          default: ;
        endcase
      end
      FMT_PERMIT2: begin
        case (idx)
          0: s = mk_span(11, 2, 10, 1, 0, 1, 0);
          1: s = mk_span(14, 12, 13, 1, 0, 1, 0);
          2: s = mk_span(21, 15, 20, 1, 0, 1, 0);
          3: s = mk_span(29, 23, 28, 1, 0, 1, 0);
          4: s = mk_span(59, 2, 21, 23, 29, 49, 58);
          default: ;
        endcase
      end
      default: begin
        case (idx)
          0: s = mk_span(9, 0, 8, 1, 0, 1, 0);
          1: s = mk_span(19, 13, 18, 1, 0, 1, 0);
          2: s = mk_span(27, 21, 26, 1, 0, 1, 0);
          3: s = mk_span(42, 28, 41, 1, 0, 1, 0);
          4: s = mk_span(43, 0, 9, 13, 19, 21, 42);
          default: ;
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic logic covers(input span_t s, input int p);
    return (p >= s.lo0 && p <= s.hi0) || (p >= s.lo1 && p <= s.hi1) ||
           (p >= s.lo2 && p <= s.hi2);
  endfunction

  // Only digits, capital letters and the filler are legal MRZ characters.
  function automatic logic char_bad(input logic [7:0] ch);
    return !((ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) ||
             (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) || ch == CH_FILLER);
  endfunction

  function automatic int char_val(input logic [7:0] ch);
    if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) return int'(ch) - int'(CH_DIGIT_0);
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) return int'(ch) - int'(CH_UPPER_A) + 10;
    return 0;
  endfunction

  function automatic int weight_of(input int ph);
    case (ph)
      0:       return 7;
      1:       return 3;
      default: return 1;
    endcase
  endfunction

  function automatic void clear_code_state();
    int i;
    pos_cnt = 7'd0;
    for (i = 0; i < NumFields; i++) begin
      sum_acc[i] = 4'd0;
      phase_acc[i] = 2'd0;
    end
    bad_flags = 5'd0;
    match_flags = 5'd0;
  endfunction

  // Takes one accepted character. On the last one of a code it queues the
  // verdict and starts over; characters past the format's length only move
  // the position counter, which saturates.
  function automatic void absorb_char(input logic [7:0] ch, input logic last);
    logic [1:0]   f;
    span_t        sp;
    logic         bad;
    logic [3:0]   ck;
    logic [4:0]   mask;
    logic         short_code;
    mcdv_result_t r;
    int           v;
    int           s;
    int           i;
    f = eff_fmt(fmt_reg);
    bad = char_bad(ch);
    v = char_val(ch);
    // A check character reads as its low nibble after removing the '0' bias,
    // so letters there still produce a value.
    ck = 4'(ch - CH_DIGIT_0);
    if (int'(pos_cnt) < code_len(f)) begin
      for (i = 0; i < NumFields; i++) begin
        sp = span_of(f, i);
        if (covers(sp, int'(pos_cnt))) begin
          if (bad) begin
            bad_flags[i] = 1'b1;
          end else begin
            sum_acc[i] = 4'((int'(sum_acc[i]) + v * weight_of(int'(phase_acc[i]))) % 10);
          end
          phase_acc[i] = (phase_acc[i] == 2'd2) ? 2'd0 : phase_acc[i] + 2'd1;
        end
        if (pos_cnt == sp.chk) begin
          s = bad_flags[i] ? 0 : int'(sum_acc[i]);
          match_flags[i] = (4'(s) == ck);
        end
      end
    end
    if (pos_cnt != PosSaturate) begin
      pos_cnt = pos_cnt + 7'd1;
    end
    if (last) begin
      mask = field_mask(f);
      short_code = int'(pos_cnt) < code_len(f);
      r.all_valid = !short_code && ((match_flags & mask) == mask);
      r.field_ok = match_flags & mask;
      r.too_short = short_code;
      expected_verdicts = {expected_verdicts, r};
      clear_code_state();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Character side. The sender offers characters in bursts of random length
  // separated by random gaps; now and then a long burst runs without gaps.
  // The model sees a character only at the edge where the request is taken.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    absorb_char(ch, last);
    chars_sent++;
  endtask

  // Stops offering characters and waits until every predicted verdict has
  // come back, then lets the pipeline settle, since a code still in progress
  // may be inside the block without any verdict pending.
  task automatic wait_until_quiet(input int settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Writes doc_format once the block is idle.
  task automatic set_doc_format(input logic [1:0] fmt);
    wait_until_quiet(PipeSettle);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= fmt;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    fmt_reg = fmt;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_mrz_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return CH_DIGIT_0 + 8'($urandom_range(0, 9));
    if (r < 17) return CH_UPPER_A + 8'($urandom_range(0, 25));
    return CH_FILLER;
  endfunction

  // Builds a code of the current format with random content and correct
  // check digits, damages it as asked and sends it. With switch_fmt set, the
  // format register is rewritten somewhere inside the code.
  task automatic send_code(input code_kind_e kind, input bit switch_fmt);
    logic [7:0] chars [$];
    logic [1:0] f;
    span_t      sp;
    int         len;
    int         n;
    int         acc;
    int         ph;
    int         i;
    int         p;
    int         split;
    int         extra;
    f = eff_fmt(fmt_reg);
    len = code_len(f);
    for (p = 0; p < len; p++) begin
      chars = {chars, pick_mrz_char()};
    end
    // Fields in ascending order, so the composite sees the final field
    // check digits it covers.
    for (i = 0; i < NumFields; i++) begin
      sp = span_of(f, i);
      if (int'(sp.chk) < len) begin
        acc = 0;
        ph = 0;
        for (p = 0; p < len; p++) begin
          if (covers(sp, p)) begin
            acc = (acc + char_val(chars[p]) * weight_of(ph)) % 10;
            ph = (ph + 1) % 3;
          end
        end
        chars[sp.chk] = CH_DIGIT_0 + 8'(acc);
      end
    end
    case (kind)
      CODE_BAD_DIGIT: chars[$urandom_range(0, len - 1)] = pick_mrz_char();
      CODE_BAD_CHAR:  chars[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
      CODE_SHORT: begin
        n = $urandom_range(1, len - 1);
        while (chars.size() > n) void'(chars.pop_back());
      end
      CODE_LONG: begin
        // Occasionally long enough to saturate the position counter.
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(128, 140) - len
                                            : $urandom_range(1, 8);
        repeat (extra) chars = {chars, 8'($urandom_range(0, 255))};
      end
      CODE_NOISE: begin
        n = $urandom_range(1, len + 4);
        chars.delete();
        repeat (n) chars = {chars, 8'($urandom_range(0, 255))};
      end
      default: ;
    endcase
    split = (switch_fmt && chars.size() > 1) ? $urandom_range(1, chars.size() - 1) : -1;
    for (p = 0; p < chars.size(); p++) begin
      if (p == split) begin
        set_doc_format(2'($urandom_range(0, 3)));
      end
      send_char(chars[p], p == chars.size() - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side. Ready follows a random pattern, picked anew whenever its
  // countdown runs out; a separate process can hold it low for a long stretch on request.
  // --------------------------------------------------------------------------
  rx_mode_e rx_mode = RX_ALWAYS;
  int       mode_left = 0;
  logic     hold_active = 1'b0;
  int       hold_requests = 0;
  int       holds_served = 0;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      mode_left <= $urandom_range(16, 96);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (hold_active) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= mode_left[3];
      endcase
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_active <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_active <= 1'b0;
      end
    end
  end

  // Each verdict taken from the block is compared with the oldest prediction.
  mcdv_result_t got_verdict;
  mcdv_result_t want_verdict;

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MaxReported) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_verdict = mcdv_result_t'(m_axis_tdata[6:0]);
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("%0t: verdict %0h arrived with none expected", $time, m_axis_tdata);
        end
      end else begin
        want_verdict = expected_verdicts.pop_front();
        if (got_verdict.all_valid !== want_verdict.all_valid) begin
          report_mismatch("all_valid", want_verdict.all_valid, got_verdict.all_valid);
        end
        if (got_verdict.field_ok !== want_verdict.field_ok) begin
          report_mismatch("field_ok", want_verdict.field_ok, got_verdict.field_ok);
        end
        if (got_verdict.too_short !== want_verdict.too_short) begin
          report_mismatch("too_short", want_verdict.too_short, got_verdict.too_short);
        end
        if (m_axis_tdata[7] !== 1'b0) begin
          report_mismatch("pad bit", 0, m_axis_tdata[7]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Character codes at both ends of the byte range, the filler and legal
  // characters, as one- and two-character codes that end far too short.
  task automatic test_char_extremes();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(CH_FILLER, 1'b1);
    send_char(CH_UPPER_Z, 1'b0);
    send_char(CH_DIGIT_9, 1'b1);
  endtask

  // One correct code per format, the unused format code included; these
  // must all pass.
  task automatic test_clean_codes();
    set_doc_format(FMT_PASSPORT);
    send_code(CODE_CLEAN, 1'b0);
    set_doc_format(FMT_PERMIT1);
    send_code(CODE_CLEAN, 1'b0);
    set_doc_format(FMT_PERMIT2);
    send_code(CODE_CLEAN, 1'b0);
    set_doc_format(2'd3);
    send_code(CODE_CLEAN, 1'b0);
  endtask

  // A code that stops before its checks and one that runs on past its end.
  task automatic test_short_and_extra();
    set_doc_format(FMT_PERMIT1);
    send_code(CODE_SHORT, 1'b0);
    send_code(CODE_LONG, 1'b0);
  endtask

  // The format register changes while a code is partway in.
  task automatic test_format_switch();
    set_doc_format(FMT_PERMIT2);
    send_code(CODE_CLEAN, 1'b1);
    send_code(CODE_BAD_DIGIT, 1'b1);
  endtask

  // One-character codes back to back while the result side holds off, so
  // the block fills up and has to stall the character stream.
  task automatic test_back_pressure();
    hold_requests <= hold_requests + 1;
    burst_left = 64;
    repeat (40) send_char(pick_mrz_char(), 1'b1);
    wait_until_quiet(PipeSettle);
  endtask

  // Half of the codes well-formed with random content, the rest damaged, cut
  // short, overlong or plain noise, with occasional format changes.
  task automatic test_random_codes();
    int first_char;
    int codes;
    int r;
    code_kind_e kind;
    first_char = chars_sent;
    codes = 0;
    while (chars_sent - first_char < RandomChars || codes < MinRandCodes) begin
      if ($urandom_range(0, 5) == 0) begin
        set_doc_format(2'($urandom_range(0, 3)));
      end
      r = $urandom_range(0, 99);
      if (r < 50)      kind = CODE_CLEAN;
      else if (r < 64) kind = CODE_BAD_DIGIT;
      else if (r < 74) kind = CODE_BAD_CHAR;
      else if (r < 84) kind = CODE_SHORT;
      else if (r < 93) kind = CODE_LONG;
      else             kind = CODE_NOISE;
      send_code(kind, $urandom_range(0, 15) == 0);
      codes++;
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_char_extremes();
    test_clean_codes();
    test_short_and_extra();
    test_format_switch();
    test_back_pressure();
    test_random_codes();
    wait_until_quiet(FinalSettle);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mcdv_pkg.sv
rtl/core/mcdv_in_stage.sv
rtl/core/mcdv_accum.sv
rtl/core/mcdv_out_stage.sv
rtl/core/mrz_check_digit_validator.sv
sim/mrz_check_digit_validator_test.sv
